FILE: rtl/ipfd_pkg.sv
`default_nettype none
package ipfd_pkg;

  localparam int DEF_CHANNELS    = 6;
  localparam int DEF_FRAME_BITS  = 32;
  localparam int DEF_HOLD_OFF_US = 10000;

  localparam int CH_FIELD_W  = 3;
  localparam int TIME_W      = 32;
  localparam int WIN_W       = 20;
  localparam int DATA_W      = 32;
  localparam int REG_COUNT   = 8;
  localparam int ADDR_W      = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] KIND_EDGE      = 2'd0;
  localparam logic [1:0] KIND_READ      = 2'd1;
  localparam logic [1:0] KIND_READ_NONE = 2'd2;

  localparam logic [2:0] REG_SIGN_MIN = 3'd0;
  localparam logic [2:0] REG_SIGN_MAX = 3'd1;
  localparam logic [2:0] REG_GAP_MIN  = 3'd2;
  localparam logic [2:0] REG_GAP_MAX  = 3'd3;
  localparam logic [2:0] REG_ONE_MIN  = 3'd4;
  localparam logic [2:0] REG_ONE_MAX  = 3'd5;
  localparam logic [2:0] REG_ZERO_MIN = 3'd6;
  localparam logic [2:0] REG_ZERO_MAX = 3'd7;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CH_FIELD_W-1:0] channel;
    logic [TIME_W-1:0]     time_us;
    logic                  edge_rising;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]     frame_data;
    logic                  frame_valid;
    logic [CH_FIELD_W-1:0] channel;
  } res_t;

  typedef struct packed {
    logic [WIN_W-1:0] lo;
    logic [WIN_W-1:0] hi;
  } win_t;

  typedef struct packed {
    win_t sign;
    win_t gap;
    win_t one;
    win_t zero;
  } win_set_t;

  // Both bounds are inclusive; an inverted window matches nothing.
  function automatic logic in_win(logic [TIME_W-1:0] d, win_t w);
    return (d >= TIME_W'(w.lo)) && (d <= TIME_W'(w.hi));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ipfd_queue.sv
`default_nettype none
module ipfd_queue import ipfd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTH
  a_fill_never_over_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_push_pop_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && pop && !empty) |=> (count_r == $past(count_r)))
    else $error("simultaneous push and pop changed the fill count");
`endif

endmodule
`default_nettype wire

FILE: rtl/ipfd_front.sv
`default_nettype none
module ipfd_front import ipfd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  wire logic                  push,
  input  wire logic                  q_full,
  input  wire logic                  in_mode,
  input  wire logic [CH_FIELD_W-1:0] in_channel,
  input  wire logic [TIME_W-1:0]     in_time_us,
  input  wire logic                  in_edge_rising,
  output logic                       q_push,
  output cmd_t                       cmd
);

  logic in_range;

  // Edges on channels that do not exist are dropped here and never queued.
  assign in_range = ({2'b00, in_channel} < 5'(CHANNELS));

  always_comb begin
    cmd.channel     = in_channel;
    cmd.time_us     = in_time_us;
    cmd.edge_rising = in_edge_rising;
    if (in_mode == MODE_EDGE) begin
      cmd.kind = KIND_EDGE;
    end else if (in_range) begin
      cmd.kind = KIND_READ;
    end else begin
      cmd.kind = KIND_READ_NONE;
    end
    q_push = push && !q_full && ((in_mode == MODE_READ) || in_range);
  end

endmodule
`default_nettype wire

FILE: rtl/ipfd_back.sv
`default_nettype none
module ipfd_back import ipfd_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int FRAME_BITS  = DEF_FRAME_BITS,
  parameter int HOLD_OFF_US = DEF_HOLD_OFF_US
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire win_set_t win,
  input  wire logic     cmd_empty,
  input  wire cmd_t     cmd,
  output logic          cmd_pop,
  input  wire logic     res_full,
  output logic          res_push,
  output res_t          res
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BT_W = $clog2(FRAME_BITS + 1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_GAP  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]        phase_r [CHANNELS];
  logic              armed_r [CHANNELS];
  logic [TIME_W-1:0] last_r  [CHANNELS];
  logic [DATA_W-1:0] word_r  [CHANNELS];
  logic [BT_W-1:0]   bits_r  [CHANNELS];

  logic [3:0]        ch_ext;
  logic [CH_W-1:0]   idx;
  logic [2:0]        cur_phase, phase_nxt;
  logic              cur_armed, armed_nxt;
  logic [TIME_W-1:0] cur_last, last_nxt;
  logic [DATA_W-1:0] cur_word, word_nxt;
  logic [BT_W-1:0]   cur_bits, bits_nxt;
  logic [TIME_W-1:0] d;
  logic [DATA_W-1:0] bit_mask;
  logic              room;
  logic              wr_en;

  assign ch_ext    = {1'b0, cmd.channel};
  assign idx       = ch_ext[CH_W-1:0];
  assign cur_phase = phase_r[idx];
  assign cur_armed = armed_r[idx];
  assign cur_last  = last_r[idx];
  assign cur_word  = word_r[idx];
  assign cur_bits  = bits_r[idx];

  assign d    = cmd.time_us - cur_last;
  assign room = (cur_bits < BT_W'(FRAME_BITS));

  assign cmd_pop  = !cmd_empty && ((cmd.kind == KIND_EDGE) || !res_full);
  assign res_push = cmd_pop && (cmd.kind != KIND_EDGE);
  assign wr_en    = cmd_pop && ((cmd.kind == KIND_EDGE) || (cmd.kind == KIND_READ));

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      bit_mask[i] = (int'(cur_bits) == i);
    end
  end

  always_comb begin
    phase_nxt = cur_phase;
    armed_nxt = cur_armed;
    last_nxt  = cur_last;
    word_nxt  = cur_word;
    bits_nxt  = cur_bits;
    if (cmd.kind == KIND_EDGE) begin
      if (cmd.edge_rising == cur_armed) begin
        last_nxt = cmd.time_us;
        case (cur_phase)
          PH_IDLE: begin
            armed_nxt = 1'b1;
            phase_nxt = PH_SIGN;
          end
          PH_SIGN: begin
            armed_nxt = 1'b0;
            if (in_win(d, win.sign)) begin
              phase_nxt = PH_GAP;
            end else begin
              phase_nxt = PH_IDLE;
              word_nxt  = '0;
              bits_nxt  = '0;
            end
          end
          PH_GAP: begin
            armed_nxt = 1'b1;
            if (in_win(d, win.gap)) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              word_nxt  = '0;
              bits_nxt  = '0;
            end
          end
          PH_DATA: begin
            armed_nxt = 1'b0;
            if (room && in_win(d, win.one)) begin
              word_nxt  = cur_word | bit_mask;
              bits_nxt  = cur_bits + BT_W'(1);
              phase_nxt = PH_GAP;
            end else if (room && in_win(d, win.zero)) begin
              word_nxt  = cur_word & ~bit_mask;
              bits_nxt  = cur_bits + BT_W'(1);
              phase_nxt = PH_GAP;
            end else begin
              phase_nxt = PH_IDLE;
              word_nxt  = '0;
              bits_nxt  = '0;
            end
            if (bits_nxt == BT_W'(FRAME_BITS)) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            if (d >= TIME_W'(HOLD_OFF_US)) begin
              armed_nxt = 1'b1;
              phase_nxt = PH_SIGN;
              word_nxt  = '0;
              bits_nxt  = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            word_nxt  = '0;
            bits_nxt  = '0;
          end
        endcase
      end
    end else if ((cmd.kind == KIND_READ) && (cur_phase == PH_DONE)) begin
      phase_nxt = PH_IDLE;
      armed_nxt = 1'b0;
      word_nxt  = '0;
      bits_nxt  = '0;
    end
  end

  always_comb begin
    res.channel     = cmd.channel;
    res.frame_valid = 1'b0;
    res.frame_data  = '0;
    if ((cmd.kind == KIND_READ) && (cur_phase == PH_DONE)) begin
      res.frame_valid = 1'b1;
      res.frame_data  = cur_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        phase_r[c] <= PH_IDLE;
        armed_r[c] <= 1'b0;
        last_r[c]  <= '0;
        word_r[c]  <= '0;
        bits_r[c]  <= '0;
      end
    end else if (wr_en) begin
      phase_r[idx] <= phase_nxt;
      armed_r[idx] <= armed_nxt;
      last_r[idx]  <= last_nxt;
      word_r[idx]  <= word_nxt;
      bits_r[idx]  <= bits_nxt;
    end
  end

`ifndef SYNTH
  a_read_hit_clears_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.frame_valid) |=> (phase_r[$past(idx)] == PH_IDLE))
    else $error("channel not idle after its frame was read");

  a_done_means_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd.kind == KIND_EDGE))
      |=> ((phase_r[$past(idx)] != PH_DONE) || (bits_r[$past(idx)] == BT_W'(FRAME_BITS))))
    else $error("channel done without a full frame");
`endif

endmodule
`default_nettype wire

FILE: rtl/ir_pulse_width_frame_decoder.sv
`default_nettype none
// Path: a read beat passes the input queue and the result queue, both registered, before it
//   reaches the result side; edge beats produce no result and update the channel registers.
// Throughput: one beat per cycle, set by the back end, which updates one channel's registers
//   per cycle; a stalled result side holds read beats only once the result queue is full.
// Reset: synchronous, active low; every channel goes idle with the falling edge armed, all
//   windows read zero and both queues empty. The block takes beats right after reset.
module ir_pulse_width_frame_decoder import ipfd_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int FRAME_BITS  = DEF_FRAME_BITS,
  parameter int HOLD_OFF_US = DEF_HOLD_OFF_US
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel.
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_mode,
  input  wire logic [CH_FIELD_W-1:0] in_channel,
  input  wire logic [TIME_W-1:0]     in_time_us,
  input  wire logic                  in_edge_rising,
  // Result channel.
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [DATA_W-1:0]     out_frame_data,
  output logic                       out_frame_valid,
  output logic      [CH_FIELD_W-1:0] out_out_channel,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  // The eight window registers sit at word addresses; only the low 20 bits of a
  // write are kept. A read at an address that is not word aligned returns zero.
  logic [WIN_W-1:0] regs_r [REG_COUNT];
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  win_set_t         win;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[1:0] == 2'b00) ? CFG_DATA_W'(regs_r[reg_idx]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REG_COUNT; r++) begin
        regs_r[r] <= '0;
      end
    end else if (cfg_wr) begin
      regs_r[reg_idx] <= pwdata[WIN_W-1:0];
    end
  end

  assign win.sign.lo = regs_r[REG_SIGN_MIN];
  assign win.sign.hi = regs_r[REG_SIGN_MAX];
  assign win.gap.lo  = regs_r[REG_GAP_MIN];
  assign win.gap.hi  = regs_r[REG_GAP_MAX];
  assign win.one.lo  = regs_r[REG_ONE_MIN];
  assign win.one.hi  = regs_r[REG_ONE_MAX];
  assign win.zero.lo = regs_r[REG_ZERO_MIN];
  assign win.zero.hi = regs_r[REG_ZERO_MAX];

  // The front end tags each beat as an edge, a read, or a read of a channel
  // that does not exist, and drops edges on such channels before queueing.
  logic q_push;
  cmd_t front_cmd;
  cmd_t queued_cmd;
  logic cmd_full, cmd_empty, cmd_pop;

  ipfd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .push          (push),
    .q_full        (cmd_full),
    .in_mode       (in_mode),
    .in_channel    (in_channel),
    .in_time_us    (in_time_us),
    .in_edge_rising(in_edge_rising),
    .q_push        (q_push),
    .cmd           (front_cmd)
  );

  assign full = cmd_full;

  ipfd_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(front_cmd),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(queued_cmd),
    .empty(cmd_empty)
  );

  // The back end owns all per-channel decoder state. It retires one queued
  // beat per cycle and waits only when a read finds the result queue full.
  logic res_push, res_full;
  res_t back_res;
  res_t head_res;

  ipfd_back #(
    .CHANNELS   (CHANNELS),
    .FRAME_BITS (FRAME_BITS),
    .HOLD_OFF_US(HOLD_OFF_US)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .win      (win),
    .cmd_empty(cmd_empty),
    .cmd      (queued_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  ipfd_queue #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(back_res),
    .full (res_full),
    .pop  (pop),
    .rdata(head_res),
    .empty(empty)
  );

  assign out_frame_data  = head_res.frame_data;
  assign out_frame_valid = head_res.frame_valid;
  assign out_out_channel = head_res.channel;

`ifndef SYNTH
  a_invalid_result_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_frame_valid) |-> (out_frame_data == '0))
    else $error("invalid result carries a nonzero word");

  a_result_channel_exists: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_valid) |-> ({2'b00, out_out_channel} < 5'(CHANNELS)))
    else $error("valid frame reported for a channel that does not exist");
`endif

endmodule
`default_nettype wire

FILE: sim/ir_pulse_width_frame_decoder_test.sv
`default_nettype none
module ir_pulse_width_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipfd_pkg::*;

  localparam int CHANNELS       = DEF_CHANNELS;
  localparam int FRAME_BITS     = DEF_FRAME_BITS;
  localparam int HOLD_OFF_US    = DEF_HOLD_OFF_US;
  // Cycles to let pass once the last read result is back. This covers edge beats that
  // still sit in the input queue or the back end before a register is touched.
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int LONG_HOLD      = 300;

  // Decoder phases of one channel, in the order the frame walks through them.
  typedef enum logic [2:0] {
    DEC_IDLE, DEC_SIGN, DEC_GAP, DEC_DATA, DEC_DONE
  } dec_phase_e;

  // One read result as it shows up on the out_ ports.
  typedef struct packed {
    logic [DATA_W-1:0]     data;
    logic                  valid;
    logic [CH_FIELD_W-1:0] ch;
  } frame_t;

  // One row of the opening script. Rows with typed set carry their own answer.
  typedef struct packed {
    logic                  mode;
    logic [CH_FIELD_W-1:0] ch;
    logic [TIME_W-1:0]     stamp;
    logic                  rising;
    logic                  typed;
    frame_t                want;
  } opening_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic                  in_mode;
  logic [CH_FIELD_W-1:0] in_channel;
  logic [TIME_W-1:0]     in_time_us;
  logic                  in_edge_rising;
  logic                  empty;
  logic                  pop;
  logic [DATA_W-1:0]     out_frame_data;
  logic                  out_frame_valid;
  logic [CH_FIELD_W-1:0] out_out_channel;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ir_pulse_width_frame_decoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_channel      (in_channel),
    .in_time_us      (in_time_us),
    .in_edge_rising  (in_edge_rising),
    .empty           (empty),
    .pop             (pop),
    .out_frame_data  (out_frame_data),
    .out_frame_valid (out_frame_valid),
    .out_out_channel (out_out_channel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5ns clk = ~clk;

  // Shadow copy of every channel's decoder and of the window registers. It is advanced
  // once per accepted input beat, so it always matches what the block has been told.
  dec_phase_e            ch_phase        [CHANNELS];
  logic                  ch_armed_rising [CHANNELS];
  logic [TIME_W-1:0]     ch_last_edge    [CHANNELS];
  logic [DATA_W-1:0]     ch_word         [CHANNELS];
  logic [5:0]            ch_bits         [CHANNELS];
  logic [WIN_W-1:0]      window_reg      [REG_COUNT];

  frame_t      frames_due [$];
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  // Cleared for stretches so that both sides run back to back with no idle cycles.
  bit          gaps_on          = 1'b1;
  // Set by the stimulus to make the result side hold off for a long stretch.
  bit          hold_results_req = 1'b0;

  // The opening script. It starts from the reset windows, which are all zero, so only a
  // pulse of exactly zero microseconds matches any window and the one window wins over the
  // zero window. Reads of idle or unknown channels have an obvious answer and carry it here.
  opening_row_t opening_rows [22] = '{
    // Reads right after reset: nothing is finished anywhere, including out-of-range channels.
    '{MODE_READ, 3'd0, 32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 3'd0}},
    '{MODE_READ, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd0, 1'b0, 3'd7}},
    '{MODE_READ, 3'd6, 32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 3'd6}},
    // An edge on a channel past the last one is dropped.
    '{MODE_EDGE, 3'd7, 32'h0000_0000, 1'b0, 1'b0, '0},
    // Channel 0 arms on the falling edge after reset, so a rising edge does nothing.
    '{MODE_EDGE, 3'd0, 32'h0000_0005, 1'b1, 1'b0, '0},
    // Signature and interval of zero length at the top of the time range, then a pulse of
    // one microsecond across the wrap that fits no window and sends the channel back idle.
    '{MODE_EDGE, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd0, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{MODE_READ, 3'd0, 32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 3'd0}},
    // Channel 1 takes one bit where the one and zero windows overlap.
    '{MODE_EDGE, 3'd1, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd1, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 3'd1, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd1, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{MODE_READ, 3'd1, 32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 3'd1}},
    // Longest possible pulse on the last channel: the difference is all ones.
    '{MODE_EDGE, 3'd5, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd5, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
    '{MODE_READ, 3'd5, 32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 3'd5}},
    // Alternating time patterns on channel 2; the interval fits no window and the channel goes idle.
    '{MODE_EDGE, 3'd2, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 3'd2, 32'h5555_5555, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 3'd2, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{MODE_READ, 3'd2, 32'hAAAA_AAAA, 1'b1, 1'b0, '0}
  };

  // A pulse fits a window when it lies between both bounds, inclusive.
  function automatic bit pulse_fits(logic [TIME_W-1:0] d, logic [2:0] lo, logic [2:0] hi);
    return d >= TIME_W'(window_reg[lo]) && d <= TIME_W'(window_reg[hi]);
  endfunction

  function automatic bit window_open(logic [2:0] lo, logic [2:0] hi);
    return window_reg[lo] <= window_reg[hi];
  endfunction

  // A pulse length inside the window, or any length at all if the window is inverted.
  function automatic logic [TIME_W-1:0] length_in(logic [2:0] lo, logic [2:0] hi);
    if (!window_open(lo, hi)) return $urandom;
    return $urandom_range(window_reg[hi], window_reg[lo]);
  endfunction

  // A pulse length past the upper bound of both given windows.
  function automatic logic [TIME_W-1:0] length_past(logic [2:0] hi_a, logic [2:0] hi_b);
    logic [TIME_W-1:0] top;
    top = (window_reg[hi_a] > window_reg[hi_b]) ? TIME_W'(window_reg[hi_a])
                                                : TIME_W'(window_reg[hi_b]);
    return top + 1 + $urandom_range(0, 999);
  endfunction

  task automatic wipe_channel(input int c);
    ch_phase[c] = DEC_IDLE;
    ch_word[c]  = '0;
    ch_bits[c]  = '0;
  endtask

  task automatic reset_decoders();
    for (int c = 0; c < CHANNELS; c++) begin
      wipe_channel(c);
      ch_armed_rising[c] = 1'b0;
      ch_last_edge[c]    = '0;
    end
    for (int r = 0; r < REG_COUNT; r++) window_reg[r] = '0;
  endtask

  // Advances the shadow decoders by one accepted beat. A read always yields a result;
  // an edge never does.
  task automatic decode_beat(input logic mode, input logic [CH_FIELD_W-1:0] ch,
                             input logic [TIME_W-1:0] stamp, input logic rising,
                             output bit has_res, output frame_t res);
    logic [TIME_W-1:0] d;
    int                c;
    c       = int'(ch);
    has_res = 1'b0;
    res     = '0;
    if (mode == MODE_READ) begin
      has_res = 1'b1;
      res.ch  = ch;
      if (c < CHANNELS && ch_phase[c] == DEC_DONE) begin
        res.data  = ch_word[c];
        res.valid = 1'b1;
        wipe_channel(c);
        ch_armed_rising[c] = 1'b0;
      end
    end else if (c < CHANNELS && rising == ch_armed_rising[c]) begin
      d               = stamp - ch_last_edge[c];
      ch_last_edge[c] = stamp;
      case (ch_phase[c])
        DEC_IDLE: begin
          ch_armed_rising[c] = 1'b1;
          ch_phase[c]        = DEC_SIGN;
        end
        DEC_SIGN: begin
          ch_armed_rising[c] = 1'b0;
          if (pulse_fits(d, REG_SIGN_MIN, REG_SIGN_MAX)) ch_phase[c] = DEC_GAP;
          else wipe_channel(c);
        end
        DEC_GAP: begin
          ch_armed_rising[c] = 1'b1;
          if (pulse_fits(d, REG_GAP_MIN, REG_GAP_MAX)) ch_phase[c] = DEC_DATA;
          else wipe_channel(c);
        end
        DEC_DATA: begin
          // The one window is tried first, so it wins where the two overlap.
          ch_armed_rising[c] = 1'b0;
          if (pulse_fits(d, REG_ONE_MIN, REG_ONE_MAX)) begin
            ch_word[c][ch_bits[c][4:0]] = 1'b1;
            ch_bits[c]++;
            ch_phase[c] = DEC_GAP;
          end else if (pulse_fits(d, REG_ZERO_MIN, REG_ZERO_MAX)) begin
            ch_word[c][ch_bits[c][4:0]] = 1'b0;
            ch_bits[c]++;
            ch_phase[c] = DEC_GAP;
          end else begin
            wipe_channel(c);
          end
          if (ch_bits[c] == FRAME_BITS) ch_phase[c] = DEC_DONE;
        end
        default: begin
          // A finished frame survives short pulses; a long quiet spell starts a new one.
          if (d >= TIME_W'(HOLD_OFF_US)) begin
            ch_armed_rising[c] = 1'b1;
            ch_phase[c]        = DEC_SIGN;
            ch_word[c]         = '0;
            ch_bits[c]         = '0;
          end
        end
      endcase
    end
  endtask

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endfunction

  // Offers one input beat after a random pause and waits until the block takes it. The
  // expected result is queued from the shadow decoders unless the caller supplies it.
  task automatic send_beat(input logic mode, input logic [CH_FIELD_W-1:0] ch,
                           input logic [TIME_W-1:0] stamp, input logic rising,
                           input bit typed = 1'b0, input frame_t want = '0);
    int unsigned pause;
    bit          has_res;
    frame_t      res;
    pause = gaps_on ? $urandom_range(0, 7) : 0;
    if (pause != 0) begin
      push <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    push           <= 1'b1;
    in_mode        <= mode;
    in_channel     <= ch;
    in_time_us     <= stamp;
    in_edge_rising <= rising;
    do @(posedge clk); while (full);
    decode_beat(mode, ch, stamp, rising, has_res, res);
    if (has_res) frames_due.push_back(typed ? want : res);
  endtask

  // Stops offering beats and waits until every read has come back and any trailing
  // edge beats have had time to reach the channel registers.
  task automatic settle();
    push <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one window register, then reads it back through the same port. The select
  // stays high so that the next register can follow right away.
  task automatic cfg_write(input logic [2:0] idx, input logic [WIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_reg[idx] = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(value))
      note_mismatch("register readback", 64'(value), 64'(prdata));
  endtask

  task automatic load_windows(input logic [WIN_W-1:0] sign_lo, input logic [WIN_W-1:0] sign_hi,
                              input logic [WIN_W-1:0] gap_lo,  input logic [WIN_W-1:0] gap_hi,
                              input logic [WIN_W-1:0] one_lo,  input logic [WIN_W-1:0] one_hi,
                              input logic [WIN_W-1:0] zero_lo, input logic [WIN_W-1:0] zero_hi);
    cfg_write(REG_SIGN_MIN, sign_lo);
    cfg_write(REG_SIGN_MAX, sign_hi);
    cfg_write(REG_GAP_MIN,  gap_lo);
    cfg_write(REG_GAP_MAX,  gap_hi);
    cfg_write(REG_ONE_MIN,  one_lo);
    cfg_write(REG_ONE_MAX,  one_hi);
    cfg_write(REG_ZERO_MIN, zero_lo);
    cfg_write(REG_ZERO_MAX, zero_hi);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends the edge that carries channel c one step further through a frame. With stray
  // set the pulse misses the window that the current phase needs.
  task automatic advance_channel(input int c, input bit stray);
    logic [TIME_W-1:0] d;
    case (ch_phase[c])
      DEC_IDLE: d = $urandom_range(0, 50000);
      DEC_SIGN: d = stray ? length_past(REG_SIGN_MAX, REG_SIGN_MAX)
                          : length_in(REG_SIGN_MIN, REG_SIGN_MAX);
      DEC_GAP:  d = stray ? length_past(REG_GAP_MAX, REG_GAP_MAX)
                          : length_in(REG_GAP_MIN, REG_GAP_MAX);
      DEC_DATA: begin
        if (stray)
          d = length_past(REG_ONE_MAX, REG_ZERO_MAX);
        else if (($urandom_range(0, 1) == 1 && window_open(REG_ONE_MIN, REG_ONE_MAX)) ||
                 !window_open(REG_ZERO_MIN, REG_ZERO_MAX))
          d = length_in(REG_ONE_MIN, REG_ONE_MAX);
        else
          d = length_in(REG_ZERO_MIN, REG_ZERO_MAX);
      end
      default:  d = ($urandom_range(0, 1) == 1) ? $urandom_range(0, HOLD_OFF_US - 1)
                                                : $urandom_range(HOLD_OFF_US, 200000);
    endcase
    send_beat(MODE_EDGE, CH_FIELD_W'(c), ch_last_edge[c] + d, ch_armed_rising[c]);
  endtask

  // Burst of reads with no gaps while the result side is told to hold off, so that both
  // queues fill and the block has to push back on the input.
  task automatic squeeze_results();
    bit saved_gaps;
    saved_gaps       = gaps_on;
    gaps_on          = 1'b0;
    hold_results_req = 1'b1;
    repeat (24)
      send_beat(MODE_READ, CH_FIELD_W'($urandom_range(0, CHANNELS - 1)), $urandom,
                1'($urandom));
    gaps_on = saved_gaps;
  endtask

  // Random traffic under one window setting. Most beats walk one focus channel through
  // well-formed frames with random bits; the rest are beats on other channels, broken
  // pulses, wrong-polarity edges, noise on any channel number and stray reads.
  task automatic random_traffic(input int unsigned count, input bit with_squeeze);
    int unsigned useful;
    int unsigned roll;
    int          focus;
    int          c;
    bit          squeezed;
    useful   = 0;
    squeezed = 1'b0;
    focus    = $urandom_range(0, CHANNELS - 1);
    while (useful < count) begin
      gaps_on = (useful % 100) >= 20;
      if (with_squeeze && !squeezed && useful >= count / 2) begin
        squeeze_results();
        squeezed = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if (ch_phase[focus] == DEC_DONE && $urandom_range(0, 3) != 0) begin
          send_beat(MODE_READ, CH_FIELD_W'(focus), $urandom, 1'($urandom));
          focus = $urandom_range(0, CHANNELS - 1);
        end else begin
          advance_channel(focus, 1'b0);
        end
        useful++;
      end else if (roll < 87) begin
        advance_channel($urandom_range(0, CHANNELS - 1), 1'b0);
        useful++;
      end else if (roll < 88) begin
        advance_channel(focus, 1'b1);
        useful++;
      end else if (roll < 92) begin
        // Wrong polarity: the block must leave the channel alone.
        c = $urandom_range(0, CHANNELS - 1);
        send_beat(MODE_EDGE, CH_FIELD_W'(c), $urandom, ~ch_armed_rising[c]);
      end else if (roll < 95) begin
        send_beat(MODE_EDGE, CH_FIELD_W'($urandom_range(0, 7)), $urandom, 1'($urandom));
      end else begin
        send_beat(MODE_READ, CH_FIELD_W'($urandom_range(0, 7)), $urandom, 1'($urandom));
        useful++;
      end
    end
  endtask

  // Result side: pops after a random pause and checks each beat against the oldest
  // expectation. A hold request from the stimulus turns one pause into a long stretch.
  initial begin
    int unsigned pause;
    frame_t      want;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pause = gaps_on ? $urandom_range(0, 7) : 0;
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        pause            = LONG_HOLD;
      end
      if (pause != 0) begin
        pop <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (frames_due.size() == 0) begin
        note_mismatch("unexpected result, channel", '0, 64'(out_out_channel));
      end else begin
        want = frames_due.pop_front();
        if (out_frame_data !== want.data)   note_mismatch("frame_data", 64'(want.data),
                                                          64'(out_frame_data));
        if (out_frame_valid !== want.valid) note_mismatch("frame_valid", 64'(want.valid),
                                                          64'(out_frame_valid));
        if (out_out_channel !== want.ch)    note_mismatch("out_channel", 64'(want.ch),
                                                          64'(out_out_channel));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_mode        <= MODE_EDGE;
    in_channel     <= '0;
    in_time_us     <= '0;
    in_edge_rising <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    reset_decoders();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_beat(opening_rows[i].mode, opening_rows[i].ch, opening_rows[i].stamp,
                opening_rows[i].rising, opening_rows[i].typed, opening_rows[i].want);
    settle();

    // Realistic timing with disjoint windows; the long result hold happens here.
    load_windows(20'd9000, 20'd9500, 20'd500, 20'd600,
                 20'd1600, 20'd1750, 20'd500, 20'd650);
    random_traffic(96, 1'b1);
    settle();

    // Overlapping bit windows and a signature window of a single value.
    load_windows(20'd2000, 20'd2000, 20'd0, 20'd50,
                 20'd100, 20'd300, 20'd200, 20'd400);
    random_traffic(96, 1'b0);
    settle();

    // Widest bounds; the one window is inverted, so every finished frame holds zero.
    load_windows(20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF,
                 20'hFFFFF, 20'd0, 20'd0, 20'hFFFFF);
    random_traffic(96, 1'b0);
    settle();

    // The zero window is inverted and the one window spans everything: all-ones frames.
    load_windows(20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF,
                 20'd0, 20'hFFFFF, 20'd5, 20'd4);
    random_traffic(96, 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ipfd_pkg.sv
rtl/ipfd_queue.sv
rtl/ipfd_front.sv
rtl/ipfd_back.sv
rtl/ir_pulse_width_frame_decoder.sv
sim/ir_pulse_width_frame_decoder_test.sv
